[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the fire alarm sequencer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FAS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FAS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FAS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define FAS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hdl/fas_pkg.sv]
// ----------------------------------------------------------------------------
// fas_pkg
// types, constants and helpers for the fire alarm sequencer
// ----------------------------------------------------------------------------
package fas_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [CFG_W-1:0] POLL_PERIOD_RST    = CFG_W'(200);
    localparam logic [CFG_W-1:0] DOOR_RUN_TIME_RST  = CFG_W'(3000);
    localparam logic [CFG_W-1:0] BLINK_INTERVAL_RST = CFG_W'(500);

    // register index, paddr[3:2]
    localparam logic [1:0] REG_POLL_PERIOD    = 2'd0;
    localparam logic [1:0] REG_DOOR_RUN_TIME  = 2'd1;
    localparam logic [1:0] REG_BLINK_INTERVAL = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RAISE = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REP_NONE     = 2'd0,
        REP_DETECTED = 2'd1,
        REP_CLEARED  = 2'd2
    } t_report;

    typedef logic [TIMER_BITS-1:0] t_timer;

    typedef struct packed {
        logic [CFG_W-1:0] poll_period;
        logic [CFG_W-1:0] door_run_time;
        logic [CFG_W-1:0] blink_interval;
    } t_cfg;

    typedef struct packed {
        logic   active;
        logic   doors_halted;
        logic   warn_phase;
        logic   toggle_forced;
        logic   rain_last;
        t_timer poll_elapsed;
        t_timer alarm_elapsed;
        t_timer blink_elapsed;
    } t_state;

    typedef struct packed {
        logic    alarm_on;
        logic    warning_on;
        logic    open_pulse;
        logic    door_stop_pulse;
        t_report fire_report;
        t_report rain_report;
    } t_result;

    function automatic t_timer sat_inc(input t_timer v);
        return (&v) ? v : t_timer'(v + 1'b1);
    endfunction

    function automatic logic [CMP_W-1:0] ext_timer(input t_timer v);
        return CMP_W'(v);
    endfunction

    function automatic logic [CMP_W-1:0] ext_cfg(input logic [CFG_W-1:0] v);
        return CMP_W'(v);
    endfunction

endpackage

[hdl/fas_in_if.sv]
// ----------------------------------------------------------------------------
// fas_in_if
// input channel: tick or command items with sensor levels
// ----------------------------------------------------------------------------
interface fas_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       flame_seen;
    logic       rain_seen;

    modport source (output valid, output cmd, output flame_seen, output rain_seen,
                    input ready);
    modport sink (input valid, input cmd, input flame_seen, input rain_seen,
                  output ready);
endinterface

[hdl/fas_out_if.sv]
// ----------------------------------------------------------------------------
// fas_out_if
// result channel: alarm status, pulses and reports
// ----------------------------------------------------------------------------
interface fas_out_if;
    logic       valid;
    logic       ready;
    logic       alarm_on;
    logic       warning_on;
    logic       open_pulse;
    logic       door_stop_pulse;
    logic [1:0] fire_report;
    logic [1:0] rain_report;

    modport source (output valid, output alarm_on, output warning_on, output open_pulse,
                    output door_stop_pulse, output fire_report, output rain_report,
                    input ready);
    modport sink (input valid, input alarm_on, input warning_on, input open_pulse,
                  input door_stop_pulse, input fire_report, input rain_report,
                  output ready);
endinterface

[hdl/fas_step.sv]
// ----------------------------------------------------------------------------
// fas_step
// next state and result for one item, pure combinational
// ----------------------------------------------------------------------------
module fas_step (
    input  fas_pkg::t_state  i_state,
    input  fas_pkg::t_cfg    i_cfg,
    input  logic [1:0]       i_cmd,
    input  logic             i_flame_seen,
    input  logic             i_rain_seen,
    output fas_pkg::t_state  o_state,
    output fas_pkg::t_result o_result
);

    fas_pkg::t_state  s;
    fas_pkg::t_result res;
    logic             due;

    always_comb begin
        s   = i_state;
        due = 1'b0;
        res.alarm_on        = 1'b0;
        res.warning_on      = 1'b0;
        res.open_pulse      = 1'b0;
        res.door_stop_pulse = 1'b0;
        res.fire_report     = fas_pkg::REP_NONE;
        res.rain_report     = fas_pkg::REP_NONE;

        case (fas_pkg::t_cmd'(i_cmd))
            fas_pkg::CMD_RAISE: begin
                if (!s.active) begin
                    s.active        = 1'b1;
                    s.alarm_elapsed = '0;
                    s.doors_halted  = 1'b0;
                    s.warn_phase    = 1'b1;
                    s.toggle_forced = 1'b1;
                    res.open_pulse  = 1'b1;
                    res.fire_report = fas_pkg::REP_DETECTED;
                end
            end
            fas_pkg::CMD_CLEAR: begin
                if (s.active) begin
                    s.active        = 1'b0;
                    s.warn_phase    = 1'b0;
                    s.toggle_forced = 1'b0;
                    res.fire_report = fas_pkg::REP_CLEARED;
                end
            end
            fas_pkg::CMD_TICK: begin
                s.poll_elapsed  = fas_pkg::sat_inc(s.poll_elapsed);
                s.alarm_elapsed = fas_pkg::sat_inc(s.alarm_elapsed);
                s.blink_elapsed = fas_pkg::sat_inc(s.blink_elapsed);

                due = fas_pkg::ext_timer(s.poll_elapsed) >=
                      fas_pkg::ext_cfg(i_cfg.poll_period);

                if (due && i_flame_seen && !s.active) begin
                    s.active        = 1'b1;
                    s.alarm_elapsed = '0;
                    s.doors_halted  = 1'b0;
                    s.warn_phase    = 1'b1;
                    s.toggle_forced = 1'b1;
                    res.open_pulse  = 1'b1;
                    res.fire_report = fas_pkg::REP_DETECTED;
                end else if (due && !i_flame_seen && s.active) begin
                    s.active        = 1'b0;
                    s.warn_phase    = 1'b0;
                    s.toggle_forced = 1'b0;
                    res.fire_report = fas_pkg::REP_CLEARED;
                end

                if (s.active) begin
                    if (!s.doors_halted && (fas_pkg::ext_timer(s.alarm_elapsed) >
                                            fas_pkg::ext_cfg(i_cfg.door_run_time))) begin
                        s.doors_halted      = 1'b1;
                        res.door_stop_pulse = 1'b1;
                    end
                    // forced toggle comes first after a raise
                    if (s.toggle_forced || (fas_pkg::ext_timer(s.blink_elapsed) >
                                            fas_pkg::ext_cfg(i_cfg.blink_interval))) begin
                        s.toggle_forced = 1'b0;
                        s.blink_elapsed = '0;
                        s.warn_phase    = !s.warn_phase;
                    end
                end

                if (due) begin
                    s.poll_elapsed = '0;
                    if (i_rain_seen != s.rain_last) begin
                        s.rain_last     = i_rain_seen;
                        res.rain_report = i_rain_seen ? fas_pkg::REP_DETECTED
                                                      : fas_pkg::REP_CLEARED;
                    end
                end
            end
            default: begin
                // unused code, status only
            end
        endcase

        res.alarm_on   = s.active;
        res.warning_on = s.active & s.warn_phase;
    end

    assign o_state  = s;
    assign o_result = res;

endmodule

[hdl/fire_alarm_sequencer_core.sv]
// a result item is valid in the cycle after its input item is accepted
// throughput: one item per cycle while the result channel is not stalled, set by the single state update in fas_step
// input ready stays high while the result register is empty or being taken
// reset (synchronous, active low) clears all state and the result register
// and loads the configuration registers with their defaults
// ----------------------------------------------------------------------------
// fire_alarm_sequencer_core
// fire alarm sequencer with apb configuration port and valid/ready channels
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fire_alarm_sequencer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fas_in_if.sink                       i_in,
    fas_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fas_pkg::PADDR_W-1:0]  paddr,
    input  logic [fas_pkg::PDATA_W-1:0]  pwdata,
    output logic [fas_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    fas_pkg::t_cfg    r_cfg;
    fas_pkg::t_state  r_state;
    fas_pkg::t_state  n_state;
    fas_pkg::t_result r_result;
    fas_pkg::t_result n_result;
    logic             r_out_valid;
    logic             in_ready;
    logic             in_accept;
    logic             cfg_write;
    logic [1:0]       reg_idx;

    assign reg_idx   = paddr[3:2];
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_period    <= fas_pkg::POLL_PERIOD_RST;
            r_cfg.door_run_time  <= fas_pkg::DOOR_RUN_TIME_RST;
            r_cfg.blink_interval <= fas_pkg::BLINK_INTERVAL_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                fas_pkg::REG_POLL_PERIOD:    r_cfg.poll_period    <= pwdata[fas_pkg::CFG_W-1:0];
                fas_pkg::REG_DOOR_RUN_TIME:  r_cfg.door_run_time  <= pwdata[fas_pkg::CFG_W-1:0];
                fas_pkg::REG_BLINK_INTERVAL: r_cfg.blink_interval <= pwdata[fas_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            fas_pkg::REG_POLL_PERIOD:    prdata = fas_pkg::PDATA_W'(r_cfg.poll_period);
            fas_pkg::REG_DOOR_RUN_TIME:  prdata = fas_pkg::PDATA_W'(r_cfg.door_run_time);
            fas_pkg::REG_BLINK_INTERVAL: prdata = fas_pkg::PDATA_W'(r_cfg.blink_interval);
            default:                     prdata = '0;
        endcase
    end

    // result register doubles as the stage boundary
    assign in_ready   = !r_out_valid || o_out.ready;
    assign i_in.ready = in_ready;
    assign in_accept  = i_in.valid & in_ready;

    fas_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_cmd        (i_in.cmd),
        .i_flame_seen (i_in.flame_seen),
        .i_rain_seen  (i_in.rain_seen),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
            r_result    <= '0;
        end else begin
            if (in_accept) begin
                r_state  <= n_state;
                r_result <= n_result;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.alarm_on        = r_result.alarm_on;
    assign o_out.warning_on      = r_result.warning_on;
    assign o_out.open_pulse      = r_result.open_pulse;
    assign o_out.door_stop_pulse = r_result.door_stop_pulse;
    assign o_out.fire_report     = r_result.fire_report;
    assign o_out.rain_report     = r_result.rain_report;

    `FAS_ASSERT_IMP(a_open_reports, i_clk, i_rst_n, r_out_valid && r_result.open_pulse, r_result.alarm_on && (r_result.fire_report == fas_pkg::REP_DETECTED), "open pulse without alarm detected")
    `FAS_ASSERT_IMP(a_stop_when_active, i_clk, i_rst_n, r_out_valid && r_result.door_stop_pulse, r_result.alarm_on && r_state.doors_halted, "door stop while alarm inactive")
    `FAS_ASSERT_IMP(a_cleared_inactive, i_clk, i_rst_n, r_out_valid && (r_result.fire_report == fas_pkg::REP_CLEARED), !r_result.alarm_on && !r_result.warning_on, "cleared report while alarm on")
    `FAS_ASSERT_NXT(a_hold_stalled, i_clk, i_rst_n, r_out_valid && !o_out.ready, r_out_valid && $stable(r_state), "stalled result lost or state advanced")

endmodule
